@@ hdl/regression_gated_score_ratchet_defines.svh @@
// Assertion macros shared by the regression-gated score ratchet RTL.
// Depends on nothing; included by the files that carry concurrent checks.
`ifndef REGRESSION_GATED_SCORE_RATCHET_DEFINES_SVH
`define REGRESSION_GATED_SCORE_RATCHET_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGSR_ASSERT_HOLD(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rgsr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RGSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rgsr: next-cycle check failed");

`endif

@@ hdl/rgsr_pkg.sv @@
// Package for the regression-gated score ratchet: sequencer states, codes
// and Q1.16 constants. Depends on nothing.
package rgsr_pkg;

    localparam int unsigned SCORE_W           = 17;
    localparam int unsigned DEF_HISTORY_DEPTH = 32;

    localparam logic [16:0] SCORE_ONE         = 17'd65536;
    localparam logic [7:0]  PAUSE_AFTER_RESET = 8'd3;
    localparam logic [7:0]  STRIKE_MAX        = 8'd255;

    localparam logic [1:0] OP_SUBMIT  = 2'd0;
    localparam logic [1:0] OP_RESUME  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] DEC_ACCEPTED = 2'd0;
    localparam logic [1:0] DEC_ROLLBACK = 2'd1;
    localparam logic [1:0] DEC_SKIPPED  = 2'd2;
    localparam logic [1:0] DEC_CONTROL  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_OLDSQ,
        S_NEWSQ,
        S_ADDSQ,
        S_DISP,
        S_MNQ,
        S_MNS,
        S_PREP,
        S_DIV,
        S_SAT,
        S_DONE
    } t_state;

endpackage

@@ hdl/regression_gated_score_ratchet.sv @@
// Top level of the regression-gated score ratchet: control, score ring memory,
// shared multiplier and restoring divider. Depends on rgsr_pkg and the defines header.
`include "regression_gated_score_ratchet_defines.svh"

// Each input beat is one command: submit a Q1.16 score (inputs above 1.0
// saturate to 1.0), resume from pause, or restart with a baseline. A submit
// that does not fall below the current score is accepted and pushed into a
// ring of the last HISTORY_DEPTH accepted scores; a lower one is rolled back
// and counts a strike, and enough consecutive strikes latch a pause during
// which submits are skipped. Every command yields exactly one report beat,
// whose dispersion field is floor((n*Q - S*S) / (n*S)) over the ring,
// saturated at 1.0 and zero for fewer than two entries or a zero sum. The
// block holds one command at a time and drops o_s_tready until the report
// has been moved into the output register, which may still wait for the
// downstream side while the next command is already being worked on. A command
// passes through the ring update (read-before-write of the oldest entry and two
// squarings; not taken when nothing is pushed into the ring), the three
// products on the shared multiplier, then one quotient bit per cycle from the
// restoring divider, 2*(17+log2 depth) bits wide (44 at the default depth of
// 32), and then saturation and the hand-off to the output register; commands
// with a flat or tiny ring skip the divider.
module regression_gated_score_ratchet #(
    parameter int unsigned HISTORY_DEPTH = rgsr_pkg::DEF_HISTORY_DEPTH,
    localparam int unsigned CW       = $clog2(HISTORY_DEPTH + 1),
    localparam int unsigned OUT_BITS = 177 + CW,
    localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration: pause_after register.
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    // Command stream.
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [23:0]      i_s_tdata,   // [16:0] score, rest zero
    input  logic [1:0]       i_s_tuser,   // [1:0] opcode
    // Report stream.
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // From bit 0 up: cycle number 32, level before 17, level after 17, delta 18,
    // decision 2, pause hit 1, paused 1, strike count 8, dispersion 17,
    // ring entries CW, accepts 32, rollbacks 32, zero fill.
    output logic [OUT_W-1:0] o_m_tdata
);

    localparam int unsigned SCW  = rgsr_pkg::SCORE_W;
    localparam int unsigned LG   = $clog2(HISTORY_DEPTH);
    localparam int unsigned HW   = LG;
    localparam int unsigned SW   = SCW + LG;          // ring sum
    localparam int unsigned QW   = 2 * SCW - 1 + LG;  // ring sum of squares
    localparam int unsigned NUMW = 2 * SW;            // dividend
    localparam int unsigned DW   = CW + SW;           // divisor n*S
    localparam int unsigned MAW  = QW;
    localparam int unsigned MBW  = SW;
    localparam int unsigned PW   = MAW + MBW;
    localparam int unsigned STW  = $clog2(NUMW);
    localparam int unsigned DISP_LO = 96;

    rgsr_pkg::t_state r_state, n_state;

    // Architectural state.
    logic [7:0]    r_pause_after;
    logic [SCW-1:0] r_cur;
    logic          r_paused;
    logic [7:0]    r_strikes;
    logic [31:0]   r_cycles;
    logic [31:0]   r_acc_total;
    logic [31:0]   r_rb_total;
    logic [HW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_sum;
    logic [QW-1:0] r_sq;
    logic          r_zero_ok;

    // Score ring memory and its read register.
    logic [SCW-1:0] r_ring [HISTORY_DEPTH];
    logic [SCW-1:0] r_rd;

    // Per-command working registers.
    logic [SCW-1:0] r_v;
    logic           r_old_ok;
    logic [31:0]    r_rep_cyc;
    logic [SCW-1:0] r_rep_before;
    logic [17:0]    r_rep_delta;
    logic [1:0]     r_rep_dec;
    logic           r_rep_now;
    logic [PW-1:0]  r_prod;
    logic [NUMW-1:0] r_num;
    logic [NUMW-1:0] r_den;
    logic [DW-1:0]  r_dvs;
    logic [DW:0]    r_rem;
    logic [STW-1:0] r_step;
    logic [SCW-1:0] r_disp;

    // Output register.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    // Combinational helpers.
    logic             accept;
    logic [SCW-1:0]   sat;
    logic [17:0]      n_delta;
    logic [7:0]       n_strikes;
    logic             is_submit_live;
    logic             submit_ok;
    logic [SCW-1:0]   old_val;
    logic [MAW-1:0]   m_a;
    logic [MBW-1:0]   m_b;
    logic [PW-1:0]    m_p;
    logic [DW:0]      rem_sh;
    logic             rem_ge;
    logic             out_load;
    logic [OUT_W-1:0] n_out;
    logic [HW-1:0]    head_nxt;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == rgsr_pkg::S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign out_load   = (r_state == rgsr_pkg::S_DONE) && (!r_out_valid || i_m_tready);

    assign sat = (i_s_tdata[SCW-1:0] > rgsr_pkg::SCORE_ONE) ? rgsr_pkg::SCORE_ONE
                                                             : i_s_tdata[SCW-1:0];
    assign n_delta        = {1'b0, sat} - {1'b0, r_cur};
    assign n_strikes      = (r_strikes == rgsr_pkg::STRIKE_MAX) ? r_strikes
                                                                : r_strikes + 8'd1;
    assign is_submit_live = (i_s_tuser == rgsr_pkg::OP_SUBMIT) && !r_paused;
    assign submit_ok      = (sat >= r_cur);
    assign old_val        = r_old_ok ? r_rd : '0;
    assign head_nxt = (r_head == HW'(HISTORY_DEPTH - 1)) ? '0 : r_head + HW'(1);

    // The shared multiplier: one product per cycle, always registered.
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            rgsr_pkg::S_OLDSQ: begin
                m_a = MAW'(old_val);
                m_b = MBW'(old_val);
            end
            rgsr_pkg::S_NEWSQ: begin
                m_a = MAW'(r_v);
                m_b = MBW'(r_v);
            end
            rgsr_pkg::S_DISP: begin
                m_a = MAW'(r_sum);
                m_b = r_sum;
            end
            rgsr_pkg::S_MNQ: begin
                m_a = r_sq;
                m_b = MBW'(r_count);
            end
            rgsr_pkg::S_MNS: begin
                m_a = MAW'(r_sum);
                m_b = MBW'(r_count);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end
    assign m_p = PW'(m_a) * PW'(m_b);

    // One restoring division step.
    assign rem_sh = {r_rem[DW-1:0], r_num[NUMW-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_dvs});

    // Report word.
    always_comb begin
        n_out = '0;
        n_out[OUT_BITS-1:0] = {r_rb_total, r_acc_total, r_count, r_disp, r_strikes,
                               r_paused, r_rep_now, r_rep_dec, r_rep_delta, r_cur,
                               r_rep_before, r_rep_cyc};
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rgsr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rgsr_pkg::S_IDLE: begin
                if (accept) begin
                    if ((i_s_tuser == rgsr_pkg::OP_RESTART) ||
                        (is_submit_live && submit_ok)) begin
                        n_state = rgsr_pkg::S_PUSH;
                    end else begin
                        n_state = rgsr_pkg::S_DISP;
                    end
                end
            end
            rgsr_pkg::S_PUSH:  n_state = rgsr_pkg::S_OLDSQ;
            rgsr_pkg::S_OLDSQ: n_state = rgsr_pkg::S_NEWSQ;
            rgsr_pkg::S_NEWSQ: n_state = rgsr_pkg::S_ADDSQ;
            rgsr_pkg::S_ADDSQ: n_state = rgsr_pkg::S_DISP;
            rgsr_pkg::S_DISP: begin
                if ((r_count < CW'(2)) || (r_sum == '0)) begin
                    n_state = rgsr_pkg::S_DONE;
                end else begin
                    n_state = rgsr_pkg::S_MNQ;
                end
            end
            rgsr_pkg::S_MNQ:  n_state = rgsr_pkg::S_MNS;
            rgsr_pkg::S_MNS:  n_state = rgsr_pkg::S_PREP;
            rgsr_pkg::S_PREP: begin
                if (r_num <= r_den) begin
                    n_state = rgsr_pkg::S_DONE;
                end else begin
                    n_state = rgsr_pkg::S_DIV;
                end
            end
            rgsr_pkg::S_DIV: begin
                if (r_step == STW'(NUMW - 1)) begin
                    n_state = rgsr_pkg::S_SAT;
                end
            end
            rgsr_pkg::S_SAT: n_state = rgsr_pkg::S_DONE;
            rgsr_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = rgsr_pkg::S_IDLE;
                end
            end
            default: n_state = rgsr_pkg::S_IDLE;
        endcase
    end

    // Ring memory: the oldest entry is read out as the new score is written.
    always_ff @(posedge i_clk) begin
        if (r_state == rgsr_pkg::S_PUSH) begin
            r_rd           <= r_ring[r_head];
            r_ring[r_head] <= r_v;
        end
    end

    // Control state: scores, counters, ring bookkeeping and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause_after <= rgsr_pkg::PAUSE_AFTER_RESET;
            r_cur         <= '0;
            r_paused      <= 1'b0;
            r_strikes     <= '0;
            r_cycles      <= '0;
            r_acc_total   <= '0;
            r_rb_total    <= '0;
            r_head        <= HW'(1);
            r_count       <= CW'(1);
            r_sum         <= '0;
            r_sq          <= '0;
            r_zero_ok     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_pause_after <= i_cfg_wr_data;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                rgsr_pkg::S_IDLE: begin
                    if (accept) begin
                        case (i_s_tuser)
                            rgsr_pkg::OP_SUBMIT: begin
                                if (!r_paused) begin
                                    r_cycles <= r_cycles + 32'd1;
                                    if (submit_ok) begin
                                        r_cur       <= sat;
                                        r_strikes   <= '0;
                                        r_acc_total <= r_acc_total + 32'd1;
                                    end else begin
                                        r_strikes  <= n_strikes;
                                        r_rb_total <= r_rb_total + 32'd1;
                                        if (n_strikes >= r_pause_after) begin
                                            r_paused <= 1'b1;
                                        end
                                    end
                                end
                            end
                            rgsr_pkg::OP_RESUME: begin
                                r_paused  <= 1'b0;
                                r_strikes <= '0;
                            end
                            rgsr_pkg::OP_RESTART: begin
                                r_cur       <= sat;
                                r_paused    <= 1'b0;
                                r_strikes   <= '0;
                                r_cycles    <= '0;
                                r_acc_total <= '0;
                                r_rb_total  <= '0;
                                r_head      <= '0;
                                r_count     <= '0;
                                r_sum       <= '0;
                                r_sq        <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                rgsr_pkg::S_PUSH: begin
                    if (r_count != CW'(HISTORY_DEPTH)) begin
                        r_count <= r_count + CW'(1);
                    end
                    if (r_head == '0) begin
                        r_zero_ok <= 1'b1;
                    end
                    r_head <= head_nxt;
                end
                rgsr_pkg::S_OLDSQ: begin
                    r_sum <= r_sum - SW'(old_val) + SW'(r_v);
                end
                rgsr_pkg::S_NEWSQ: begin
                    r_sq <= r_sq - r_prod[QW-1:0];
                end
                rgsr_pkg::S_ADDSQ: begin
                    r_sq <= r_sq + r_prod[QW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers of the current command; no reset needed.
    always_ff @(posedge i_clk) begin
        r_prod <= m_p;
        if (accept) begin
            r_v          <= sat;
            r_rep_cyc    <= r_cycles;
            r_rep_before <= r_cur;
            r_rep_delta  <= is_submit_live ? n_delta : '0;
            r_rep_now    <= is_submit_live && !submit_ok && (n_strikes >= r_pause_after);
            if (i_s_tuser == rgsr_pkg::OP_SUBMIT) begin
                if (r_paused) begin
                    r_rep_dec <= rgsr_pkg::DEC_SKIPPED;
                end else if (submit_ok) begin
                    r_rep_dec <= rgsr_pkg::DEC_ACCEPTED;
                end else begin
                    r_rep_dec <= rgsr_pkg::DEC_ROLLBACK;
                end
            end else begin
                r_rep_dec <= rgsr_pkg::DEC_CONTROL;
            end
        end
        case (r_state)
            rgsr_pkg::S_PUSH: begin
                r_old_ok <= (r_count == CW'(HISTORY_DEPTH)) && ((r_head != '0) || r_zero_ok);
            end
            rgsr_pkg::S_DISP: begin
                r_disp <= '0;
            end
            rgsr_pkg::S_MNQ: begin
                r_den <= r_prod[NUMW-1:0];
            end
            rgsr_pkg::S_MNS: begin
                r_num <= r_prod[NUMW-1:0];
            end
            rgsr_pkg::S_PREP: begin
                r_dvs  <= r_prod[DW-1:0];
                r_num  <= r_num - r_den;
                r_rem  <= '0;
                r_step <= '0;
            end
            rgsr_pkg::S_DIV: begin
                r_rem  <= rem_ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
                r_num  <= {r_num[NUMW-2:0], rem_ge};
                r_step <= r_step + STW'(1);
            end
            rgsr_pkg::S_SAT: begin
                r_disp <= (r_num > NUMW'(rgsr_pkg::SCORE_ONE)) ? rgsr_pkg::SCORE_ONE
                                                               : r_num[SCW-1:0];
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_data <= n_out;
        end
    end

    // Checks.
    `RGSR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !o_s_tready)
    `RGSR_ASSERT_HOLD(a_count_range, i_clk, i_rst_n, r_state == rgsr_pkg::S_IDLE,
        (r_count != '0) && (r_count <= CW'(HISTORY_DEPTH)))
    `RGSR_ASSERT_HOLD(a_rem_below_dvs, i_clk, i_rst_n, r_state == rgsr_pkg::S_DIV,
        r_rem < {1'b0, r_dvs})
    `RGSR_ASSERT_HOLD(a_disp_range, i_clk, i_rst_n, o_m_tvalid,
        r_out_data[DISP_LO+SCW-1:DISP_LO] <= rgsr_pkg::SCORE_ONE)

endmodule
